// File: hw/rtl/frsm_pkg.sv
// Package for the Fibonacci range-sum block: widths, command and status types.
// No dependencies; used by frsm_ctrl, frsm_dp and fibonacci_range_sum_mod.
package frsm_pkg;

	localparam int unsigned MOD_W = 31;
	localparam int unsigned IDX_W = 32;
	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	// datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_INIT  = 3'd1,   // load base = Q, acc = I
		OP_MULA  = 3'd2,   // acc = acc * base
		OP_SQR   = 3'd3,   // base = base * base
		OP_SAVEH = 3'd4,   // hold F(m+2) from acc
		OP_DIFF  = 3'd5    // result = hold - F(n+1)
	} dp_op_t;

	typedef struct packed {
		logic   start;     // begin one matrix product or simple op
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic done;        // matrix product finished (pulse); simple ops give none
	} dp_sts_t;

endpackage

// File: hw/rtl/frsm_modmul.sv
// Sequential modular multiplier: (a*b) mod md by MSB-first shift-and-add.
// Uses frsm_pkg for the operand width; one bit of b per cycle.
module frsm_modmul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [frsm_pkg::MOD_W-1:0] a,
	input  logic [frsm_pkg::MOD_W-1:0] b,
	input  logic [frsm_pkg::MOD_W-1:0] md,
	output logic                  done,
	output logic [frsm_pkg::MOD_W-1:0] p
);
	import frsm_pkg::*;

	localparam int unsigned CNT_W = $clog2(MOD_W + 1);

	logic [MOD_W-1:0] acc_q, b_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [MOD_W+1:0] dbl, dbl_r, add, add_r;

	// acc = 2*acc mod md, then + a mod md (a < md, acc < md)
	always_comb begin
		dbl   = {2'b0, acc_q} << 1;
		dbl_r = (dbl >= {2'b0, md}) ? dbl - {2'b0, md} : dbl;
		add   = dbl_r + (b_q[MOD_W-1] ? {2'b0, a} : '0);
		add_r = (add >= {2'b0, md}) ? add - {2'b0, md} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MOD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= add_r[MOD_W-1:0];
			b_q   <= b_q << 1;
		end
	end

	assign p = acc_q;

endmodule

// File: hw/rtl/frsm_dp.sv
// Datapath: 2x2 matrix registers, one shared modular multiplier, adder, subtract.
// Depends on frsm_pkg and frsm_modmul.
module frsm_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frsm_pkg::dp_cmd_t          cmd,
	output frsm_pkg::dp_sts_t          sts,
	input  logic [frsm_pkg::MOD_W-1:0] md,
	output logic [frsm_pkg::MOD_W-1:0] result
);
	import frsm_pkg::*;

	// matrix entries: index {row,col}
	logic [MOD_W-1:0] acc_q [4];
	logic [MOD_W-1:0] base_q [4];
	logic [MOD_W-1:0] prod_q [4];
	logic [MOD_W-1:0] hold_q, result_q, p0_q;
	logic [2:0]       step_q;      // product term 0..7: entry = step[2:1], half = step[0]
	logic             busy_q, sqr_q;
	logic             mm_start, mm_done;
	logic [MOD_W-1:0] mm_a, mm_b, mm_p;
	logic [1:0]       ij;
	logic             kk;
	logic [MOD_W:0]   sum, sum_r;
	logic [MOD_W:0]   diff;

	assign ij = step_q[2:1];
	assign kk = step_q[0];

	// operand select: left[i][k] * right[k][j]
	always_comb begin
		mm_a = sqr_q ? base_q[{ij[1], kk}] : acc_q[{ij[1], kk}];
		mm_b = base_q[{kk, ij[0]}];
		sum   = {1'b0, p0_q} + {1'b0, mm_p};
		sum_r = (sum >= {1'b0, md}) ? sum - {1'b0, md} : sum;
		diff  = (hold_q >= acc_q[3]) ? {1'b0, hold_q} - {1'b0, acc_q[3]}
		                             : {1'b0, hold_q} + {1'b0, md} - {1'b0, acc_q[3]};
	end

	frsm_modmul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start),
		.a(mm_a), .b(mm_b), .md(md), .done(mm_done), .p(mm_p)
	);

	// sequencing of the eight partial products of one matrix product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= '0;
			sqr_q    <= 1'b0;
			mm_start <= 1'b0;
			sts      <= '0;
		end else begin
			mm_start <= 1'b0;
			sts.done <= 1'b0;
			if (cmd.start && (cmd.op == OP_MULA || cmd.op == OP_SQR)) begin
				busy_q   <= 1'b1;
				sqr_q    <= (cmd.op == OP_SQR);
				step_q   <= '0;
				mm_start <= 1'b1;
			end else if (busy_q && mm_done) begin
				step_q <= step_q + 1'b1;
				if (step_q == 3'd7) begin
					busy_q   <= 1'b0;
					sts.done <= 1'b1;
				end else begin
					mm_start <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			unique case (cmd.op)
				OP_INIT: begin
					base_q[0] <= MOD_W'(1); base_q[1] <= MOD_W'(1);
					base_q[2] <= MOD_W'(1); base_q[3] <= '0;
					acc_q[0]  <= MOD_W'(1); acc_q[1]  <= '0;
					acc_q[2]  <= '0;        acc_q[3]  <= MOD_W'(1);
				end
				OP_SAVEH: hold_q   <= acc_q[1];
				OP_DIFF:  result_q <= diff[MOD_W-1:0];
				default: ;
			endcase
		end else if (busy_q && mm_done) begin
			if (!kk) p0_q <= mm_p;
			else prod_q[ij] <= sum_r[MOD_W-1:0];
			if (step_q == 3'd7) begin
				if (sqr_q) begin
					base_q[0] <= prod_q[0]; base_q[1] <= prod_q[1];
					base_q[2] <= prod_q[2]; base_q[3] <= sum_r[MOD_W-1:0];
				end else begin
					acc_q[0] <= prod_q[0]; acc_q[1] <= prod_q[1];
					acc_q[2] <= prod_q[2]; acc_q[3] <= sum_r[MOD_W-1:0];
				end
			end
		end
	end

	assign result = result_q;

endmodule

// File: hw/rtl/frsm_ctrl.sv
// Controller: walks exponent bits of m+2 then n+2, issues datapath ops.
// Depends on frsm_pkg; drives frsm_dp through dp_cmd_t / dp_sts_t.
module frsm_ctrl #(
	parameter int unsigned EXP_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	input  logic [EXP_BITS-1:0]         n_idx,
	input  logic [EXP_BITS-1:0]         m_idx,
	input  logic                        md_small,
	output logic                        busy,
	output logic                        res_valid,
	output logic                        res_zero,
	input  frsm_pkg::dp_sts_t           sts,
	output frsm_pkg::dp_cmd_t           cmd
);
	import frsm_pkg::*;

	localparam int unsigned EW    = EXP_BITS + 1;
	localparam int unsigned BIT_W = $clog2(EW + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INIT = 7'b0000010,
		S_MULA = 7'b0000100,
		S_SQR  = 7'b0001000,
		S_SAVE = 7'b0010000,
		S_DIFF = 7'b0100000,
		S_WAIT = 7'b1000000
	} state_t;

	state_t           state_q;
	logic [EW-1:0]    exp_q, n2_q;
	logic [BIT_W-1:0] bit_q;
	logic             second_q, issued_q;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issued_q  <= 1'b0;
			second_q  <= 1'b0;
			bit_q     <= '0;
			res_valid <= 1'b0;
			res_zero  <= 1'b0;
			cmd       <= '0;
		end else begin
			cmd       <= '0;
			res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					exp_q    <= {1'b0, m_idx} + EW'(2);
					n2_q     <= {1'b0, n_idx} + EW'(2);
					second_q <= 1'b0;
					res_zero <= md_small;
					if (md_small) begin
						res_valid <= 1'b1;
					end else begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					cmd      <= '{start: 1'b1, op: OP_INIT};
					bit_q    <= '0;
					state_q  <= S_MULA;
					issued_q <= 1'b0;
				end
				S_MULA: begin
					if (!exp_q[0]) begin
						state_q <= S_SQR;
					end else if (!issued_q) begin
						cmd      <= '{start: 1'b1, op: OP_MULA};
						issued_q <= 1'b1;
					end else if (sts.done) begin
						issued_q <= 1'b0;
						state_q  <= S_SQR;
					end
				end
				S_SQR: begin
					if (!issued_q) begin
						cmd      <= '{start: 1'b1, op: OP_SQR};
						issued_q <= 1'b1;
					end else if (sts.done) begin
						issued_q <= 1'b0;
						exp_q    <= exp_q >> 1;
						bit_q    <= bit_q + 1'b1;
						if (bit_q == BIT_W'(EW - 1)) begin
							state_q <= second_q ? S_DIFF : S_SAVE;
						end else begin
							state_q <= S_MULA;
						end
					end
				end
				S_SAVE: begin
					cmd      <= '{start: 1'b1, op: OP_SAVEH};
					exp_q    <= n2_q;
					second_q <= 1'b1;
					state_q  <= S_INIT;
				end
				S_DIFF: begin
					cmd     <= '{start: 1'b1, op: OP_DIFF};
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					res_valid <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// a result is produced only from idle or the final state
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ($past(state_q) == S_WAIT || $past(state_q) == S_IDLE))
		else $error("result without finishing");
	// no new op is issued while waiting for a datapath op
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		(issued_q && !sts.done) |=> !cmd.start)
		else $error("op overlap");
	// the bit counter never runs past the exponent width
	a_bits: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BIT_W'(EW))
		else $error("bit counter overrun");
`endif

endmodule

// File: hw/rtl/fibonacci_range_sum_mod.sv
// Fibonacci range sum (F(n)+...+F(m)) mod a configurable modulus.
// Each item is computed as F(m+2) - F(n+1) from two powers of [[1,1],[1,0]]
// by square-and-multiply over EXP_BITS+1 exponent bits. One item at a time:
// each matrix product is 8 modular multiplies on one shared bit-serial unit,
// and an item needs 2*(EXP_BITS+1) matrix squarings plus one matrix multiply
// per set bit of m+2 and n+2. A modulus below 2 returns 0 without running
// the datapath. The result word sits in an output register and no new word
// is taken until it has been read. Depends on frsm_pkg, frsm_ctrl, frsm_dp,
// frsm_modmul.
module fibonacci_range_sum_mod #(
	parameter int unsigned EXP_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [30:0] cfg_data,       // modulus
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,        // [31:0] low_index, [63:32] high_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata         // [30:0] range_sum, [31] zero
);
	import frsm_pkg::*;

	logic [MOD_W-1:0] mod_q, dp_res, out_q;
	logic             out_v_q, busy, res_valid, res_zero, in_fire;
	dp_cmd_t          cmd;
	dp_sts_t          sts;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_q <= MOD_RESET;
		else if (cfg_valid) mod_q <= cfg_data;
	end

	// take a word only when idle and the output slot is empty
	assign s_tready = !busy && !out_v_q && !res_valid;
	assign in_fire  = s_tvalid && s_tready;

	frsm_ctrl #(.EXP_BITS(EXP_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.n_idx(EXP_BITS'(s_tdata[31:0])), .m_idx(EXP_BITS'(s_tdata[63:32])),
		.md_small(mod_q < MOD_W'(2)), .busy(busy), .res_valid(res_valid),
		.res_zero(res_zero), .sts(sts), .cmd(cmd)
	);

	frsm_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .md(mod_q), .result(dp_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (res_valid) out_v_q <= 1'b1;
		else if (m_tready) out_v_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res_zero ? '0 : dp_res;
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

// File: tb/tb.sv
// Testbench for fibonacci_range_sum_mod: directed and random index pairs under several moduli.
// Results are checked against an in-bench matrix-power predictor. Depends on frsm_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import frsm_pkg::*;

	typedef struct {
		logic [63:0] a, b, c, d;   // [[a,b],[c,d]]
	} fib_mat_t;

	typedef struct {
		logic [IDX_W-1:0] low_index;
		logic [IDX_W-1:0] high_index;
	} index_pair_t;

	localparam int unsigned EXP_BITS = 32;
	localparam int unsigned CYCLE_LIMIT = 60_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [30:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	index_pair_t      pair_q[$];
	logic [MOD_W-1:0] sum_q[$];
	logic [MOD_W-1:0] modulus_shadow;
	logic             word_taken = 1'b0;
	logic             calm = 1'b0;
	int unsigned      cycles = 0;
	int unsigned      errors = 0;

	fibonacci_range_sum_mod #(.EXP_BITS(EXP_BITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// 2x2 matrix product, every entry product reduced
	function automatic fib_mat_t mat_product(fib_mat_t x, fib_mat_t y, logic [63:0] md);
		fib_mat_t r;
		r.a = ((x.a * y.a) % md + (x.b * y.c) % md) % md;
		r.b = ((x.a * y.b) % md + (x.b * y.d) % md) % md;
		r.c = ((x.c * y.a) % md + (x.d * y.c) % md) % md;
		r.d = ((x.c * y.b) % md + (x.d * y.d) % md) % md;
		return r;
	endfunction

	// Q^k by square-and-multiply over EXP_BITS+1 bits
	function automatic fib_mat_t fib_power(logic [63:0] k, logic [63:0] md);
		fib_mat_t base, acc;
		base = '{64'd1, 64'd1, 64'd1, 64'd0};
		acc  = '{64'd1, 64'd0, 64'd0, 64'd1};
		for (int i = 0; i < EXP_BITS + 1; i++) begin
			if (k[i])
				acc = mat_product(acc, base, md);
			base = mat_product(base, base, md);
		end
		return acc;
	endfunction

	// F(m+2) - F(n+1), wrapped into 0..md-1
	function automatic logic [MOD_W-1:0] range_sum(index_pair_t p, logic [MOD_W-1:0] modv);
		logic [63:0] md, hi, lo, res;
		fib_mat_t pm, pn;
		md = {33'd0, modv};
		if (md < 2)
			return '0;
		pm = fib_power({32'd0, p.high_index} + 64'd2, md);
		pn = fib_power({32'd0, p.low_index} + 64'd2, md);
		hi = pm.b;
		lo = pn.d;
		res = (hi >= lo) ? hi - lo : hi + md - lo;
		return res[MOD_W-1:0];
	endfunction

	// input word driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || word_taken)) begin
			if (pair_q.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
				index_pair_t p;
				p = pair_q.pop_front();
				s_tdata <= {p.high_index, p.low_index};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result stall
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= calm || $urandom_range(99) >= 11;
	end

	// monitor: predict on accepted input words, check output words, track modulus writes
	always @(posedge clk) begin
		index_pair_t p;
		logic [MOD_W-1:0] want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			word_taken = s_tvalid && s_tready;
			if (!arst_n) begin
				modulus_shadow = MOD_RESET;
			end else begin
				if (cfg_valid && cfg_ready)
					modulus_shadow = cfg_data;
				if (s_tvalid && s_tready) begin
					p.low_index = s_tdata[31:0];
					p.high_index = s_tdata[63:32];
					sum_q = {sum_q, range_sum(p, modulus_shadow)};
				end
				if (m_tvalid && m_tready) begin
					if (sum_q.size() == 0) begin
						$error("unexpected output word %h", m_tdata);
						errors++;
					end else begin
						want = sum_q.pop_front();
						if (m_tdata[30:0] !== want) begin
							$error("range_sum: expected %0d, got %0d", want, m_tdata[30:0]);
							errors++;
						end
						if (m_tdata[31] !== 1'b0) begin
							$error("pad bit: expected 0, got %b", m_tdata[31]);
							errors++;
						end
					end
				end
			end
		end
	end

	task automatic add_pair(logic [31:0] n, logic [31:0] m);
		index_pair_t p;
		p.low_index = n;
		p.high_index = m;
		pair_q = {pair_q, p};
	endtask

	// random pairs: mostly small indices for speed, some full width
	task automatic add_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				add_pair($urandom, $urandom);
			else
				add_pair($urandom_range(300), $urandom_range(300));
		end
	endtask

	// block empties: no pending words, nothing outstanding
	task automatic drain();
		wait (pair_q.size() == 0 && !s_tvalid && sum_q.size() == 0);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_modulus(logic [30:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_directed();
		add_pair(32'd0, 32'd0);
		add_pair(32'd0, 32'd1);
		add_pair(32'd1, 32'd0);
		add_pair(32'd5, 32'd10);
		add_pair(32'd10, 32'd5);
		add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_pair(32'd0, 32'hFFFF_FFFF);
		add_pair(32'hFFFF_FFFF, 32'd0);
		add_pair(32'h8000_0000, 32'hFFFF_FFFE);
		add_pair(32'h5555_5555, 32'hAAAA_AAAA);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset modulus
		add_directed();
		add_random(25);
		drain();

		// largest modulus, no idling on either side
		write_modulus(31'h7FFF_FFFF);
		calm = 1'b1;
		add_directed();
		add_random(25);
		drain();
		calm = 1'b0;

		// smallest legal modulus
		write_modulus(31'd2);
		add_pair(32'd0, 32'd0);
		add_pair(32'hFFFF_FFFF, 32'd3);
		add_random(10);
		drain();

		// degenerate moduli
		write_modulus(31'd0);
		add_pair(32'd3, 32'd9);
		add_random(5);
		drain();
		write_modulus(31'd1);
		add_pair(32'd3, 32'd9);
		add_random(5);
		drain();

		write_modulus(31'd3);
		add_random(10);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			write_modulus(31'($urandom_range(32'h7FFF_FFFF, 2)));
			add_random(20);
			drain();
		end

		if (errors == 0 && sum_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/frsm_pkg.sv
hw/rtl/frsm_modmul.sv
hw/rtl/frsm_dp.sv
hw/rtl/frsm_ctrl.sv
hw/rtl/fibonacci_range_sum_mod.sv
tb/tb.sv
